// ===== sv/prl_pkg.sv =====
// Package for the per-source rate limiter: table sizes, wave and write structs.
// Used by the core, cell and controller modules of the block.
`default_nettype none
package prl_pkg;
    localparam int SLOTS     = 256;
    localparam int IDX_W     = 8;
    localparam int OCC_W     = 9;
    localparam int CAP_W     = 13;
    localparam int TABLE_CAP = 255;
    localparam int MS_PER_SEC = 1000;
    localparam int THR_W     = 26;

    localparam logic [7:0] REG_LIMIT  = 8'd0;
    localparam logic [7:0] REG_WINDOW = 8'd1;
    localparam logic [7:0] REG_EVICT  = 8'd2;

    // token that walks the chain, one cell per cycle
    typedef struct packed {
        logic             go;
        logic             found;
        logic [IDX_W-1:0] hidx;
        logic [47:0]      hstart;
        logic [15:0]      hcount;
        logic             ffound;
        logic [IDX_W-1:0] fidx;
        logic [OCC_W-1:0] cnt;
        logic             ofound;
        logic [47:0]      ostart;
        logic [IDX_W-1:0] oidx;
    } wave_t;

    // slot write broadcast from the controller
    typedef struct packed {
        logic             en;
        logic             set;
        logic [IDX_W-1:0] idx;
        logic [31:0]      addr;
        logic [47:0]      start;
        logic [15:0]      count;
    } wr_t;
endpackage
`default_nettype wire

// ===== sv/per_source_rate_limiter_core.sv =====
// A check or forget item makes one pass of the 256-cell chain; when an allowed
// check leaves the table over its cap, the table is swept in a second pass.
// One item at a time: a new item is taken only when the controller is idle.
// Reset: synchronous active-low; clears all slot valid bits at once, the
// occupancy and the config registers to their defaults. No clearing pass.
`default_nettype none
module per_source_rate_limiter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // [31:0] source_address, [79:32] now_ms
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] allowed, [1] first_over, [10:2] entries_in_use
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    prl_pkg::wave_t w [prl_pkg::SLOTS+1];
    prl_pkg::wr_t   wr;
    logic           sweep_mode;
    logic [31:0]    key;
    logic [47:0]    now;
    logic [prl_pkg::THR_W-1:0] age_thr;

    prl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .w_head(w[0]), .w_tail(w[prl_pkg::SLOTS]),
        .sweep_mode(sweep_mode), .key(key), .now(now), .age_thr(age_thr), .wr(wr)
    );

    for (genvar i = 0; i < prl_pkg::SLOTS; i++) begin : g_cell
        prl_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .my_idx(prl_pkg::IDX_W'(i)),
            .sweep_mode(sweep_mode), .key(key), .now(now), .age_thr(age_thr),
            .wr(wr), .w_in(w[i]), .w_out(w[i+1])
        );
    end
endmodule
`default_nettype wire

// ===== sv/prl_cell.sv =====
// One table slot of the rate limiter chain: holds entry state, updates the wave.
// Depends on prl_pkg.
`default_nettype none
module prl_cell (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [prl_pkg::IDX_W-1:0] my_idx,
    input  wire logic                    sweep_mode,
    input  wire logic [31:0]             key,
    input  wire logic [47:0]             now,
    input  wire logic [prl_pkg::THR_W-1:0] age_thr,
    input  wire prl_pkg::wr_t            wr,
    input  wire prl_pkg::wave_t          w_in,
    output prl_pkg::wave_t               w_out
);
    logic        valid_reg, valid_next;
    logic [31:0] addr_reg;
    logic [47:0] start_reg;
    logic [15:0] count_reg;
    logic [47:0] elapsed;
    logic        too_old;
    logic        wr_hit;
    prl_pkg::wave_t wave_next;

    assign elapsed = (now >= start_reg) ? (now - start_reg) : 48'd0;
    // floor(elapsed/1000) > age  <=>  elapsed > age*1000+999
    assign too_old = elapsed > {22'd0, age_thr};
    assign wr_hit  = wr.en && (wr.idx == my_idx);

    always_comb begin
        wave_next  = w_in;
        valid_next = valid_reg;
        if (wr_hit) begin
            valid_next = wr.set;
        end
        if (w_in.go) begin
            if (!sweep_mode) begin
                if (valid_reg && addr_reg == key && !w_in.found) begin
                    wave_next.found  = 1'b1;
                    wave_next.hidx   = my_idx;
                    wave_next.hstart = start_reg;
                    wave_next.hcount = count_reg;
                end
                if (!valid_reg && !w_in.ffound) begin
                    wave_next.ffound = 1'b1;
                    wave_next.fidx   = my_idx;
                end
            end else if (valid_reg) begin
                if (too_old) begin
                    valid_next = 1'b0;
                end else begin
                    wave_next.cnt = w_in.cnt + 1'b1;
                    if (!w_in.ofound || start_reg < w_in.ostart) begin
                        wave_next.ofound = 1'b1;
                        wave_next.ostart = start_reg;
                        wave_next.oidx   = my_idx;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            w_out     <= '0;
        end else begin
            valid_reg <= valid_next;
            w_out     <= wave_next;
        end
        if (wr_hit && wr.set) begin
            addr_reg  <= wr.addr;
            start_reg <= wr.start;
            count_reg <= wr.count;
        end
    end
endmodule
`default_nettype wire

// ===== sv/prl_ctrl.sv =====
// Controller of the rate limiter: handshakes, config registers, wave launch,
// slot update and result register. Depends on prl_pkg.
`default_nettype none
module prl_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [79:0]             s_tdata,
    input  wire logic                    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [15:0]                  m_tdata,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [7:0]              cfg_index,
    input  wire logic [15:0]             cfg_data,
    output prl_pkg::wave_t               w_head,
    input  wire prl_pkg::wave_t          w_tail,
    output logic                         sweep_mode,
    output logic [31:0]                  key,
    output logic [47:0]                  now,
    output logic [prl_pkg::THR_W-1:0]    age_thr,
    output prl_pkg::wr_t                 wr
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOOK  = 5'b00010,
        ST_UPD   = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] limit_reg, window_reg, evict_reg;
    logic        kind_reg;
    logic [31:0] key_reg;
    logic [47:0] now_reg;
    logic [prl_pkg::THR_W-1:0] thr_reg;
    logic        inj_reg, inj_next;
    logic        mode_reg, mode_next;
    logic [prl_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic        allowed_reg, allowed_next, fo_reg, fo_next;
    logic        mv_reg;
    logic [15:0] md_reg;
    logic        s_acc;
    // lookup token as it left the last cell
    prl_pkg::wave_t tail_reg;

    logic [prl_pkg::IDX_W-1:0] tidx;
    logic [47:0] bstart, nstart, el;
    logic [15:0] bcount, ncount;
    logic [16:0] lim1;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign sweep_mode = mode_reg;
    assign key     = key_reg;
    assign now     = now_reg;
    assign age_thr = thr_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    always_comb begin
        w_head    = '0;
        w_head.go = inj_reg;
    end

    always_comb begin
        tidx   = tail_reg.found ? tail_reg.hidx : tail_reg.fidx;
        bstart = tail_reg.found ? tail_reg.hstart : 48'd0;
        bcount = tail_reg.found ? tail_reg.hcount : 16'd0;
        el     = (now_reg >= bstart) ? (now_reg - bstart) : 48'd0;
        nstart = bstart;
        ncount = bcount;
        if (el >= {32'd0, window_reg}) begin
            nstart = now_reg;
            ncount = 16'd0;
        end
        if (ncount != 16'hFFFF) begin
            ncount = ncount + 16'd1;
        end
        lim1 = {1'b0, limit_reg} + 17'd1;
    end

    always_comb begin
        state_next   = state_reg;
        inj_next     = 1'b0;
        mode_next    = mode_reg;
        occ_next     = occ_reg;
        allowed_next = allowed_reg;
        fo_next      = fo_reg;
        wr           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    inj_next     = 1'b1;
                    mode_next    = 1'b0;
                    allowed_next = 1'b0;
                    fo_next      = 1'b0;
                    state_next   = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (w_tail.go) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_OUT;
                if (kind_reg) begin
                    if (tail_reg.found) begin
                        wr.en    = 1'b1;
                        wr.idx   = tail_reg.hidx;
                        occ_next = occ_reg - 1'b1;
                    end
                end else if (tail_reg.found || tail_reg.ffound) begin
                    wr.en    = 1'b1;
                    wr.set   = 1'b1;
                    wr.idx   = tidx;
                    wr.addr  = key_reg;
                    wr.start = nstart;
                    wr.count = ncount;
                    if (!tail_reg.found) begin
                        occ_next = occ_reg + 1'b1;
                    end
                    if ({1'b0, ncount} > {1'b0, limit_reg}) begin
                        fo_next = ({1'b0, ncount} == lim1);
                    end else begin
                        allowed_next = 1'b1;
                        if ({{(prl_pkg::CAP_W-prl_pkg::OCC_W){1'b0}}, occ_next} >
                            prl_pkg::CAP_W'(prl_pkg::TABLE_CAP)) begin
                            inj_next   = 1'b1;
                            mode_next  = 1'b1;
                            state_next = ST_SWEEP;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                if (w_tail.go) begin
                    occ_next   = w_tail.cnt;
                    state_next = ST_OUT;
                    if ({{(prl_pkg::CAP_W-prl_pkg::OCC_W){1'b0}}, w_tail.cnt} >
                        prl_pkg::CAP_W'(prl_pkg::TABLE_CAP) && w_tail.ofound) begin
                        wr.en    = 1'b1;
                        wr.idx   = w_tail.oidx;
                        occ_next = w_tail.cnt - 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inj_reg     <= 1'b0;
            mode_reg    <= 1'b0;
            occ_reg     <= '0;
            allowed_reg <= 1'b0;
            fo_reg      <= 1'b0;
            mv_reg      <= 1'b0;
            limit_reg   <= 16'd100;
            window_reg  <= 16'd1000;
            evict_reg   <= 16'd60;
        end else begin
            state_reg   <= state_next;
            inj_reg     <= inj_next;
            mode_reg    <= mode_next;
            occ_reg     <= occ_next;
            allowed_reg <= allowed_next;
            fo_reg      <= fo_next;
            if (state_reg == ST_OUT && (!mv_reg || m_tready)) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    prl_pkg::REG_LIMIT:  limit_reg  <= cfg_data;
                    prl_pkg::REG_WINDOW: window_reg <= cfg_data;
                    prl_pkg::REG_EVICT:  evict_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
        if (state_reg == ST_LOOK && w_tail.go) begin
            tail_reg <= w_tail;
        end
        if (s_acc) begin
            kind_reg <= s_tuser;
            key_reg  <= s_tdata[31:0];
            now_reg  <= s_tdata[79:32];
            thr_reg  <= prl_pkg::THR_W'(evict_reg) * prl_pkg::THR_W'(1000) +
                        prl_pkg::THR_W'(999);
        end
        if (state_reg == ST_OUT && (!mv_reg || m_tready)) begin
            md_reg <= {5'd0, occ_reg, fo_reg, allowed_reg};
        end
    end
endmodule
`default_nettype wire

// ===== sv/prl_checker.sv =====
// Port-level checks of the rate limiter core, bound to the top level.
// Depends on per_source_rate_limiter_core ports only.
`default_nettype none
module prl_port_checks (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:11] == 5'd0) else $error("padding bits set");
    a_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:2] <= 9'd256) else $error("occupancy too large");
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1])) else $error("allowed and first_over");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && !s_tready |=> !m_tvalid || !s_tready)
        else $error("accepting while result blocked");
endmodule

bind per_source_rate_limiter_core prl_port_checks u_prl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ===== verif/prl_checker.sv =====
// Checker for per_source_rate_limiter_core: watches the input, result and
// config channels, predicts each result from its own table copy and compares.
// Depends on prl_pkg for the register indexes and table sizes.
`default_nettype none
module prl_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // lowest bit first: allowed, first_over, entries
    typedef struct packed {
        logic [prl_pkg::OCC_W-1:0] entries;
        logic                      first_over;
        logic                      allowed;
    } verdict_t;

    logic [15:0] lim_q, win_q, evict_q;
    bit          tbl_valid [prl_pkg::SLOTS];
    logic [31:0] tbl_addr  [prl_pkg::SLOTS];
    logic [47:0] tbl_start [prl_pkg::SLOTS];
    logic [15:0] tbl_count [prl_pkg::SLOTS];
    int          occ;
    verdict_t    expected_q[$];

    assign pending = expected_q.size();

    initial fail_count = 0;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [47:0] since(input logic [47:0] now, input logic [47:0] start);
        return (now >= start) ? now - start : 48'd0;
    endfunction

    function automatic void remove_slot(input int s);
        if (tbl_valid[s]) begin
            tbl_valid[s] = 0;
            occ--;
        end
    endfunction

    function automatic void sweep_table(input logic [47:0] now);
        int oldest;
        oldest = -1;
        for (int s = 0; s < prl_pkg::SLOTS; s++)
            if (tbl_valid[s] &&
                since(now, tbl_start[s]) / prl_pkg::MS_PER_SEC > {32'd0, evict_q})
                remove_slot(s);
        if (occ > prl_pkg::TABLE_CAP) begin
            for (int s = 0; s < prl_pkg::SLOTS; s++)
                if (tbl_valid[s] && (oldest < 0 || tbl_start[s] < tbl_start[oldest]))
                    oldest = s;
            if (oldest >= 0)
                remove_slot(oldest);
        end
    endfunction

    function automatic verdict_t rate_decision(input logic kind, input logic [31:0] addr,
                                               input logic [47:0] now);
        verdict_t v;
        int hit;
        logic [16:0] cnt;
        v = '0;
        hit = -1;
        for (int s = 0; s < prl_pkg::SLOTS; s++)
            if (hit < 0 && tbl_valid[s] && tbl_addr[s] == addr)
                hit = s;
        if (kind) begin
            if (hit >= 0)
                remove_slot(hit);
        end else begin
            if (hit < 0) begin
                for (int f = 0; f < prl_pkg::SLOTS; f++)
                    if (hit < 0 && !tbl_valid[f]) begin
                        hit = f;
                        tbl_valid[f] = 1;
                        tbl_addr[f]  = addr;
                        tbl_start[f] = '0;
                        tbl_count[f] = '0;
                        occ++;
                    end
            end
            if (hit >= 0) begin
                if (since(now, tbl_start[hit]) >= {32'd0, win_q}) begin
                    tbl_start[hit] = now;
                    tbl_count[hit] = '0;
                end
                if (tbl_count[hit] != 16'hFFFF)
                    tbl_count[hit]++;
                cnt = {1'b0, tbl_count[hit]};
                if (cnt > {1'b0, lim_q}) begin
                    v.first_over = (cnt == {1'b0, lim_q} + 17'd1);
                end else begin
                    v.allowed = 1;
                    if (occ > prl_pkg::TABLE_CAP)
                        sweep_table(now);
                end
            end
        end
        v.entries = occ[prl_pkg::OCC_W-1:0];
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t got, want;
        if (!aresetn) begin
            lim_q   <= 16'd100;
            win_q   <= 16'd1000;
            evict_q <= 16'd60;
            for (int s = 0; s < prl_pkg::SLOTS; s++)
                tbl_valid[s] = 0;
            occ = 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    prl_pkg::REG_LIMIT:  lim_q   <= cfg_data;
                    prl_pkg::REG_WINDOW: win_q   <= cfg_data;
                    prl_pkg::REG_EVICT:  evict_q <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q = {expected_q,
                              rate_decision(s_tuser, s_tdata[31:0], s_tdata[79:32])};
            if (m_tvalid && m_tready) begin
                got = verdict_t'(m_tdata[10:0]);
                if (expected_q.size() == 0) begin
                    report($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = expected_q.pop_front();
                    if (got.allowed !== want.allowed)
                        report($sformatf("allowed %b, want %b", got.allowed, want.allowed));
                    if (got.first_over !== want.first_over)
                        report($sformatf("first_over %b, want %b",
                                         got.first_over, want.first_over));
                    if (got.entries !== want.entries)
                        report($sformatf("entries_in_use %0d, want %0d",
                                         got.entries, want.entries));
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb_per_source_rate_limiter_core.sv =====
// Top testbench for per_source_rate_limiter_core: drives check/forget items
// and config writes through several settings, gives the verdict.
// Depends on prl_pkg, per_source_rate_limiter_core and prl_checker.
`default_nettype none
module tb_per_source_rate_limiter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit KIND_CHECK  = 1'b0;
    localparam bit KIND_FORGET = 1'b1;
    localparam int SETTLE      = 700;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready, s_tuser;
    logic [79:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid, cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count, pending;

    bit          tx_gaps, rx_gaps;
    int          rx_hold;
    logic [47:0] t_now;
    logic [31:0] pool [16];

    per_source_rate_limiter_core dut (.*);

    prl_checker u_checker (.*);

    always begin
        aclk = 1'b0; #6;
        aclk = 1'b1; #6;
    end

    initial begin
        #40ms;
        $display("** per_source_rate_limiter_core: FAILED **");
        $finish;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= !(rx_gaps && $urandom_range(0, 99) < 17);
            end
        end
    end

    task automatic send_item(input bit kind, input logic [31:0] addr, input logic [47:0] now);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {now, addr};
        do @(posedge aclk); while (!s_tready);
        if (tx_gaps && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // sender pauses until every expected item result is back, then settles
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(input logic [15:0] lim, input logic [15:0] win,
                            input logic [15:0] evict);
        drain();
        write_reg(prl_pkg::REG_LIMIT, lim);
        write_reg(prl_pkg::REG_WINDOW, win);
        write_reg(prl_pkg::REG_EVICT, evict);
    endtask

    function automatic logic [47:0] advance(input int step);
        if ($urandom_range(0, 99) < 3)
            return 48'({$urandom(), $urandom()});
        return t_now + 48'($urandom_range(0, step));
    endfunction

    // mostly checks against a small source pool, some forgets and fresh sources
    task automatic random_mix(input int n, input int step);
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            a = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 15)];
            t_now = advance(step);
            send_item(($urandom_range(0, 99) < 10) ? KIND_FORGET : KIND_CHECK, a, t_now);
        end
    endtask

    initial begin
        logic [31:0] base;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        rx_hold   = 0;
        tx_gaps   = 1;
        rx_gaps   = 1;
        for (int i = 0; i < 16; i++)
            pool[i] = $urandom();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default config, then limit and window of 1; extreme keys and times, forgets, time going back
        send_item(KIND_CHECK, 32'h0000_0000, 48'd0);
        send_item(KIND_CHECK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_CHECK, 32'h0000_0000, 48'd999);
        send_item(KIND_CHECK, 32'h0000_0000, 48'd1000);
        send_item(KIND_CHECK, 32'hFFFF_FFFF, 48'd5);
        send_item(KIND_FORGET, 32'h1234_5678, 48'd10);
        send_item(KIND_FORGET, 32'hFFFF_FFFF, 48'd10);
        send_item(KIND_CHECK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_CHECK, 32'hAAAA_5555, 48'hAAAA_AAAA_AAAA);
        send_item(KIND_CHECK, 32'h5555_AAAA, 48'h5555_5555_5555);
        set_regs(16'd1, 16'd1, 16'd0);
        send_item(KIND_CHECK, 32'h0000_0001, 48'd2000);
        send_item(KIND_CHECK, 32'h0000_0001, 48'd2000);
        send_item(KIND_CHECK, 32'h0000_0001, 48'd2000);
        send_item(KIND_CHECK, 32'h0000_0001, 48'd2001);
        send_item(KIND_CHECK, 32'h0000_0001, 48'd1500);
        send_item(KIND_FORGET, 32'h0000_0000, 48'd2002);

        // extremes: zero limit and window, then the top values
        set_regs(16'd0, 16'd0, 16'd0);
        t_now = 48'd3000;
        random_mix(12, 3);
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_mix(12, 3);

        // small limit and window; receiver holds off while the sender keeps offering items
        set_regs(16'd3, 16'd50, 16'd2);
        t_now = 48'd100_000;
        rx_hold = 4000;
        random_mix(260, 20);

        // fill the table past its cap: oldest-entry removal, no idling
        set_regs(16'd65533, 16'd65535, 16'd65535);
        tx_gaps = 0;
        rx_gaps = 0;
        base = $urandom();
        t_now = 48'd1_000_000;
        for (int i = 0; i < 270; i++) begin
            t_now = t_now + 48'($urandom_range(0, 3));
            send_item(KIND_CHECK, base + 32'(i), t_now);
        end
        tx_gaps = 1;
        rx_gaps = 1;

        // age-based sweep with the table near its cap
        set_regs(16'd2, 16'd1000, 16'd0);
        for (int i = 0; i < 40; i++) begin
            t_now = t_now + 48'($urandom_range(0, 700));
            send_item(($urandom_range(0, 9) == 0) ? KIND_FORGET : KIND_CHECK,
                      ($urandom_range(0, 1) != 0) ? base + 32'($urandom_range(0, 300))
                                                  : $urandom(),
                      t_now);
        end

        set_regs(16'd2, 16'd20, 16'd5);
        random_mix(240, 15);

        drain();
        if (fail_count == 0) begin
            $display("** per_source_rate_limiter_core: PASSED **");
        end else begin
            $display("** per_source_rate_limiter_core: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
